### src/scsa_pkg.sv
// ============================================================================
// scsa_pkg: shared types and constants of the size class slot allocator
// Command and status codes, payload structs, queue item and configuration.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package scsa_pkg;

    localparam int NUM_CLASSES     = 64;
    localparam int CLS_W           = 6;
    localparam int ADDR_W          = 20;
    localparam int GRAN_SHIFT      = 3;
    localparam int IDX_W           = ADDR_W - GRAN_SHIFT;
    localparam int MAX_SMALL       = 512;
    localparam int BLOCK_HEADER    = 8;
    localparam int SLOT_W          = 10;
    localparam int BODY_W          = 22;
    localparam int WIDE_W          = 23;

    localparam logic [19:0] HEAP_BASE_RST   = 20'd4096;
    localparam logic [20:0] HEAP_LIMIT_RST  = 21'd1048576;
    localparam logic [16:0] BLOCK_BYTES_RST = 17'd4096;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NULL   = 2'd1;
    localparam logic [1:0] ST_BYPASS = 2'd2;
    localparam logic [1:0] ST_OOM    = 2'd3;

    // register indexes
    localparam logic [1:0] REG_HEAP_BASE   = 2'd0;
    localparam logic [1:0] REG_HEAP_LIMIT  = 2'd1;
    localparam logic [1:0] REG_BLOCK_BYTES = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] request_size;
        logic [19:0] address;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] slot_address;
        logic [5:0]  size_class;
    } out_t;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_INIT,
        OP_NULL,
        OP_BYPASS
    } op_t;

    // classified transaction handed from front to back
    typedef struct packed {
        op_t              op;
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] idx;
    } item_t;

    typedef struct packed {
        logic [19:0] heap_base;
        logic [20:0] heap_limit;
        logic [16:0] block_bytes;
    } cfg_t;

endpackage

`default_nettype wire

### src/scsa_front.sv
// ============================================================================
// scsa_front: request classifier and command queue
// Decodes command and size into an operation and class, queues it for the back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scsa_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire scsa_pkg::in_t in_data,
    output logic               q_valid,
    output scsa_pkg::item_t    q_item,
    input  wire logic          q_pop
);
    import scsa_pkg::*;

    item_t       cls_item;
    logic [31:0] size_m1;
    logic        push;
    item_t       q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    // classify the incoming transaction
    always_comb
    begin
        size_m1      = in_data.request_size - 32'd1;
        cls_item.cls = size_m1[GRAN_SHIFT +: CLS_W];
        cls_item.idx = in_data.address[ADDR_W-1:GRAN_SHIFT];
        cls_item.op  = OP_NULL;
        case (in_data.command)
            CMD_INIT:
            begin
                cls_item.op = OP_INIT;
            end
            CMD_ALLOC, CMD_FREE:
            begin
                if (in_data.request_size > 32'(MAX_SMALL))
                    cls_item.op = OP_BYPASS;
                else if (in_data.request_size == 32'd0)
                    cls_item.op = OP_NULL;
                else if (in_data.command == CMD_ALLOC)
                    cls_item.op = OP_ALLOC;
                else if (cls_item.idx == '0)
                    cls_item.op = OP_NULL;
                else
                    cls_item.op = OP_FREE;
            end
            default:
            begin
                cls_item.op = OP_NULL;
            end
        endcase
    end

    // two-entry queue
    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### src/scsa_back.sv
// ============================================================================
// scsa_back: allocator execution engine
// Runs free list pops and pushes, bump allocation, block grants and init walk.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scsa_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire scsa_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire scsa_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output scsa_pkg::out_t       out_data
);
    import scsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARD,
        S_ALINK,
        S_FRD,
        S_GDIV,
        S_GFIN
    } state_t;

    state_t                 state_reg;
    op_t                    op_reg;
    logic [CLS_W-1:0]       cls_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [1:0]             init_st_reg;
    logic [20:0]            heap_next_reg;
    logic [NUM_CLASSES-1:0] head_vld_reg;
    logic [NUM_CLASSES-1:0] cl_vld_reg;
    logic [8:0]             rem_reg;
    logic [4:0]             bit_reg;
    logic                   out_valid_reg;
    out_t                   out_reg;

    // memories
    logic [IDX_W-1:0]       head_mem [NUM_CLASSES];
    logic [IDX_W:0]         link_mem [2**IDX_W];
    logic [40:0]            cl_mem   [NUM_CLASSES];
    logic [IDX_W-1:0]       head_rd_reg;
    logic [IDX_W:0]         link_rd_reg;
    logic [40:0]            cl_rd_reg;

    logic [CLS_W-1:0]       rd_cls;
    logic                   head_we, link_we, cl_we;
    logic [IDX_W-1:0]       head_wdata;
    logic [IDX_W:0]         link_wdata;
    logic [IDX_W-1:0]       link_addr;
    logic [40:0]            cl_wdata;

    logic                   out_free;
    logic                   out_load_idle;
    logic                   head_vld;
    logic [19:0]            cur_rd;
    logic [20:0]            lim_rd;

    // grant arithmetic
    logic [SLOT_W-1:0]      slot;
    logic [BODY_W-1:0]      body;
    logic [SLOT_W-1:0]      rem_sh, rem_nx;
    logic [SLOT_W-1:0]      pad;
    logic [WIDE_W-1:0]      first, blk_end, lim_g;
    logic [WIDE_W-1:0]      end_lim;
    logic                   g_ok;

    // bump arithmetic
    logic [19:0]            b_cur;
    logic [20:0]            b_lim;
    logic [21:0]            b_sum;
    logic [19:0]            b_nxt;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && out_free;
    // null, bypass and unknown transactions answer straight from idle
    assign out_load_idle = q_pop && !(q_item.op == OP_ALLOC || q_item.op == OP_FREE
                                      || q_item.op == OP_INIT);

    assign head_vld  = head_vld_reg[cls_reg];
    assign cur_rd    = cl_vld_reg[cls_reg] ? cl_rd_reg[40:21] : 20'd0;
    assign lim_rd    = cl_vld_reg[cls_reg] ? cl_rd_reg[20:0]  : 21'd0;

    // slot size, divider step and block grant checks
    always_comb
    begin
        slot    = {7'({1'b0, cls_reg}) + 7'd1, 3'b000};
        body    = BODY_W'(heap_next_reg) + BODY_W'(BLOCK_HEADER);
        rem_sh  = {rem_reg, body[bit_reg]};
        rem_nx  = (rem_sh >= slot) ? rem_sh - slot : rem_sh;
        pad     = (rem_reg == 9'd0) ? '0 : slot - {1'b0, rem_reg};
        first   = WIDE_W'(body) + WIDE_W'(pad);
        blk_end = WIDE_W'(heap_next_reg) + WIDE_W'(cfg.block_bytes);
        end_lim = (cfg.heap_limit > 21'(1 << ADDR_W)) ? WIDE_W'(1 << ADDR_W)
                                                      : WIDE_W'(cfg.heap_limit);
        lim_g   = blk_end + WIDE_W'(1) - WIDE_W'(slot);
        g_ok    = (blk_end <= end_lim) && (blk_end + WIDE_W'(1) >= WIDE_W'(slot))
                  && (first < lim_g);
    end

    // bump step from either stored cursor or a fresh grant
    always_comb
    begin
        if (state_reg == S_GFIN)
        begin
            b_cur = first[19:0];
            b_lim = lim_g[20:0];
        end
        else
        begin
            b_cur = cur_rd;
            b_lim = lim_rd;
        end
        b_sum = 22'(b_cur) + 22'(slot);
        b_nxt = (b_sum > 22'(b_lim)) ? b_lim[19:0] : b_sum[19:0];
    end

    // memory write controls; class reads follow the active class once busy
    always_comb
    begin
        rd_cls     = (state_reg == S_IDLE) ? q_item.cls : cls_reg;
        head_we    = 1'b0;
        head_wdata = idx_reg;
        link_we    = 1'b0;
        link_addr  = head_rd_reg;
        link_wdata = {head_vld, head_rd_reg};
        cl_we      = 1'b0;
        cl_wdata   = {b_nxt, b_lim};
        case (state_reg)
            S_ARD:
            begin
                cl_we = !head_vld && (cur_rd < 20'(lim_rd) || lim_rd[20])
                        && !(21'(cur_rd) >= lim_rd);
            end
            S_ALINK:
            begin
                head_we    = 1'b1;
                head_wdata = link_rd_reg[IDX_W-1:0];
            end
            S_FRD:
            begin
                head_we    = 1'b1;
                head_wdata = idx_reg;
                link_we    = 1'b1;
                link_addr  = idx_reg;
            end
            S_GFIN:
            begin
                if (op_reg == OP_INIT)
                begin
                    cl_we    = 1'b1;
                    cl_wdata = g_ok ? {first[19:0], lim_g[20:0]} : '0;
                end
                else
                begin
                    cl_we = g_ok;
                end
            end
            default:
            begin
                head_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        head_rd_reg <= head_mem[rd_cls];
        cl_rd_reg   <= cl_mem[rd_cls];
        link_rd_reg <= link_mem[link_addr];
        if (head_we)
            head_mem[cls_reg] <= head_wdata;
        if (link_we)
            link_mem[link_addr] <= link_wdata;
        if (cl_we)
            cl_mem[cls_reg] <= cl_wdata;
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NULL;
            cls_reg       <= '0;
            idx_reg       <= '0;
            init_st_reg   <= ST_OK;
            heap_next_reg <= 21'(HEAP_BASE_RST);
            head_vld_reg  <= '0;
            cl_vld_reg    <= '0;
            rem_reg       <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !out_load_idle)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        op_reg  <= q_item.op;
                        cls_reg <= (q_item.op == OP_INIT) ? '0 : q_item.cls;
                        idx_reg <= q_item.idx;
                        case (q_item.op)
                            OP_ALLOC:
                            begin
                                state_reg <= S_ARD;
                            end
                            OP_FREE:
                            begin
                                state_reg <= S_FRD;
                            end
                            OP_INIT:
                            begin
                                heap_next_reg <= 21'(cfg.heap_base);
                                head_vld_reg  <= '0;
                                init_st_reg   <= ST_OK;
                                rem_reg       <= '0;
                                bit_reg       <= 5'(BODY_W - 1);
                                state_reg     <= S_GDIV;
                            end
                            OP_BYPASS:
                            begin
                                out_valid_reg <= 1'b1;
                                out_reg       <= '{ST_BYPASS, 20'd0, 6'd0};
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                                out_reg       <= '{ST_NULL, 20'd0, 6'd0};
                            end
                        endcase
                    end
                end
                S_ARD:
                begin
                    if (head_vld)
                    begin
                        state_reg <= S_ALINK;
                    end
                    else if (21'(cur_rd) >= lim_rd)
                    begin
                        rem_reg   <= '0;
                        bit_reg   <= 5'(BODY_W - 1);
                        state_reg <= S_GDIV;
                    end
                    else
                    begin
                        cl_vld_reg[cls_reg] <= 1'b1;
                        out_valid_reg       <= 1'b1;
                        out_reg             <= '{ST_OK, cur_rd, cls_reg};
                        state_reg           <= S_IDLE;
                    end
                end
                S_ALINK:
                begin
                    head_vld_reg[cls_reg] <= link_rd_reg[IDX_W];
                    out_valid_reg         <= 1'b1;
                    out_reg               <= '{ST_OK, {head_rd_reg, 3'b000}, cls_reg};
                    state_reg             <= S_IDLE;
                end
                S_FRD:
                begin
                    head_vld_reg[cls_reg] <= 1'b1;
                    out_valid_reg         <= 1'b1;
                    out_reg               <= '{ST_OK, 20'd0, cls_reg};
                    state_reg             <= S_IDLE;
                end
                S_GDIV:
                begin
                    rem_reg <= rem_nx[8:0];
                    if (bit_reg == 5'd0)
                        state_reg <= S_GFIN;
                    else
                        bit_reg <= bit_reg - 5'd1;
                end
                S_GFIN:
                begin
                    if (g_ok)
                        heap_next_reg <= blk_end[20:0];
                    if (op_reg == OP_INIT)
                    begin
                        cl_vld_reg[cls_reg] <= 1'b1;
                        if (!g_ok)
                            init_st_reg <= ST_OOM;
                        if (cls_reg == CLS_W'(NUM_CLASSES - 1))
                        begin
                            out_valid_reg <= 1'b1;
                            out_reg       <= '{(g_ok ? init_st_reg : ST_OOM), 20'd0, 6'd0};
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            cls_reg   <= cls_reg + CLS_W'(1);
                            rem_reg   <= '0;
                            bit_reg   <= 5'(BODY_W - 1);
                            state_reg <= S_GDIV;
                        end
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (g_ok)
                        begin
                            cl_vld_reg[cls_reg] <= 1'b1;
                            out_reg <= '{ST_OK, first[19:0], cls_reg};
                        end
                        else
                        begin
                            out_reg <= '{ST_OOM, 20'd0, cls_reg};
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/size_class_slot_allocator.sv
// ============================================================================
// size_class_slot_allocator: segregated free list slot allocator
// Configuration registers, command front end and execution back end.
// ============================================================================
// Null and bypass answer from idle; a free runs S_FRD, a free list alloc
// S_ARD and S_ALINK, a bump alloc S_ARD, a block grant S_ARD, S_GDIV and
// S_GFIN. Init walks all 64 classes through the serial slot divider.
// Throughput is one command at a time in the back end; a two-entry queue
// in front takes commands while the back end works. Reset: classes empty,
// heap cursor at the heap_base reset value; the link store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module size_class_slot_allocator (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire scsa_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output scsa_pkg::out_t      out_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [20:0]    cfg_data
);
    import scsa_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heap_base   <= HEAP_BASE_RST;
            cfg_reg.heap_limit  <= HEAP_LIMIT_RST;
            cfg_reg.block_bytes <= BLOCK_BYTES_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEAP_BASE:   cfg_reg.heap_base   <= cfg_data[19:0];
                REG_HEAP_LIMIT:  cfg_reg.heap_limit  <= cfg_data;
                REG_BLOCK_BYTES: cfg_reg.block_bytes <= cfg_data[16:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    scsa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    scsa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
